// ----- src/fpw_pkg.sv -----
// Shared widths and codes for the four-level page walker.
`timescale 1ns / 1ps

package fpw_pkg;

  localparam int unsigned VA_W    = 48;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned LEVEL_W = 2;

  // opcode of an incoming item
  localparam logic OP_START     = 1'b0;
  localparam logic OP_READ_DATA = 1'b1;

  // kind of a result item
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // table levels, top first
  localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

  // entry flag bits
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_LARGE   = 7;

endpackage

// ----- src/fpw_req_if.sv -----
// Request channel: start items and returned table entries.
`timescale 1ns / 1ps

interface fpw_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [fpw_pkg::VA_W-1:0]    virt_addr;
  logic [fpw_pkg::PA_W-1:0]    root_table_addr;
  logic [fpw_pkg::ENTRY_W-1:0] read_data;

  modport source (output valid, opcode, virt_addr, root_table_addr, read_data,
                  input ready);
  modport sink   (input valid, opcode, virt_addr, root_table_addr, read_data,
                  output ready);
endinterface

// ----- src/fpw_rsp_if.sv -----
// Result channel: memory read requests and finished translations.
`timescale 1ns / 1ps

interface fpw_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [fpw_pkg::PA_W-1:0] read_addr;
  logic [fpw_pkg::PA_W-1:0] phys_addr;
  logic                     fault;

  modport source (output valid, kind, read_addr, phys_addr, fault, input ready);
  modport sink   (input valid, kind, read_addr, phys_addr, fault, output ready);
endinterface

// ----- src/four_level_page_walk.sv -----
// Top level of the four-level page walker.
`timescale 1ns / 1ps

// Usage:
//   req carries items in: opcode OP_START starts a walk with virt_addr and
//   root_table_addr; opcode OP_READ_DATA returns the 64-bit table entry that
//   the last read request asked for. rsp carries items out: KIND_READ asks
//   memory for the entry at read_addr, KIND_DONE ends the walk with phys_addr
//   (zero with fault set if an entry was not present).
//   Every start and every entry returned during a walk gives exactly one
//   result; read data arriving with no walk in progress gives none.
//   A start during a walk abandons that walk.
//   The result is in the output register in the cycle after the item is
//   accepted. Throughput: one item per cycle; the output register lets a
//   new item in whenever it is empty or is being taken in the same cycle.
//   A full walk therefore costs up to four memory round trips.
//   Reset (synchronous, rst high) drops any walk and empties the output.
//   When the receiver stalls, rsp holds its item and req.ready falls.
module four_level_page_walk (
  input  logic        clk,
  input  logic        rst,
  fpw_req_if.sink     req,
  fpw_rsp_if.source   rsp
);

  logic                                walk_busy, walk_busy_next;
  logic [fpw_pkg::LEVEL_W-1:0]         walk_level, walk_level_next;
  logic [fpw_pkg::VA_W-1:0]            saved_virt, saved_virt_next;

  logic                                res_valid;
  logic                                res_kind;
  logic [fpw_pkg::PA_W-1:0]            res_read_addr;
  logic [fpw_pkg::PA_W-1:0]            res_phys_addr;
  logic                                res_fault;

  logic                                out_valid;
  logic                                out_kind;
  logic [fpw_pkg::PA_W-1:0]            out_read_addr;
  logic [fpw_pkg::PA_W-1:0]            out_phys_addr;
  logic                                out_fault;

  logic                                accept;

  function automatic logic [fpw_pkg::IDX_W-1:0] table_index(
    input logic [fpw_pkg::VA_W-1:0]    va,
    input logic [fpw_pkg::LEVEL_W-1:0] lvl
  );
    logic [fpw_pkg::IDX_W-1:0] idx;
    case (lvl)
      fpw_pkg::LVL_PML4: idx = va[47:39];
      fpw_pkg::LVL_PDPT: idx = va[38:30];
      fpw_pkg::LVL_PD:   idx = va[29:21];
      fpw_pkg::LVL_PT:   idx = va[20:12];
      default:           idx = va[20:12];
    endcase
    return idx;
  endfunction

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_comb begin
    walk_busy_next  = walk_busy;
    walk_level_next = walk_level;
    saved_virt_next = saved_virt;
    res_valid       = 1'b0;
    res_kind        = fpw_pkg::KIND_READ;
    res_read_addr   = '0;
    res_phys_addr   = '0;
    res_fault       = 1'b0;

    if (req.opcode == fpw_pkg::OP_START) begin
      walk_busy_next  = 1'b1;
      walk_level_next = fpw_pkg::LVL_PML4;
      saved_virt_next = req.virt_addr;
      res_valid       = 1'b1;
      // table base is 4 KiB aligned, so the index just fills bits 11:3
      res_read_addr   = {req.root_table_addr[51:12],
                         table_index(req.virt_addr, fpw_pkg::LVL_PML4), 3'b000};
    end else if (walk_busy) begin
      res_valid = 1'b1;
      if (!req.read_data[fpw_pkg::BIT_PRESENT]) begin
        walk_busy_next = 1'b0;
        res_kind       = fpw_pkg::KIND_DONE;
        res_fault      = 1'b1;
      end else if (walk_level == fpw_pkg::LVL_PD && req.read_data[fpw_pkg::BIT_LARGE]) begin
        walk_busy_next = 1'b0;
        res_kind       = fpw_pkg::KIND_DONE;
        res_phys_addr  = {req.read_data[51:21], saved_virt[20:0]};
      end else if (walk_level == fpw_pkg::LVL_PT) begin
        walk_busy_next = 1'b0;
        res_kind       = fpw_pkg::KIND_DONE;
        res_phys_addr  = {req.read_data[51:12], saved_virt[11:0]};
      end else begin
        walk_level_next = walk_level + 2'd1;
        res_read_addr   = {req.read_data[51:12],
                           table_index(saved_virt, walk_level_next), 3'b000};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy  <= 1'b0;
      walk_level <= fpw_pkg::LVL_PML4;
      saved_virt <= '0;
      out_valid  <= 1'b0;
    end else if (accept) begin
      walk_busy  <= walk_busy_next;
      walk_level <= walk_level_next;
      saved_virt <= saved_virt_next;
      out_valid  <= res_valid;
    end else if (rsp.ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind      <= res_kind;
      out_read_addr <= res_read_addr;
      out_phys_addr <= res_phys_addr;
      out_fault     <= res_fault;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.kind      = out_kind;
  assign rsp.read_addr = out_read_addr;
  assign rsp.phys_addr = out_phys_addr;
  assign rsp.fault     = out_fault;

  // a start always produces a read request for the top-level entry
  a_start_reads: assert property (@(posedge clk) disable iff (rst)
    accept && req.opcode == fpw_pkg::OP_START
      |=> rsp.valid && rsp.kind == fpw_pkg::KIND_READ && walk_busy
          && walk_level == fpw_pkg::LVL_PML4)
    else $error("start did not issue a top-level read");

  // read requests carry no translation and are entry aligned
  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == fpw_pkg::KIND_READ
      |-> !rsp.fault && rsp.phys_addr == '0 && rsp.read_addr[2:0] == 3'b000)
    else $error("malformed read request");

  // a finished walk leaves the walker idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    accept && req.opcode == fpw_pkg::OP_READ_DATA && walk_busy
      && res_kind == fpw_pkg::KIND_DONE |=> !walk_busy)
    else $error("walker still busy after finishing");

  // a fault reports address zero
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.fault |-> rsp.kind == fpw_pkg::KIND_DONE && rsp.phys_addr == '0)
    else $error("fault with nonzero address");

endmodule
